// File: hdl/assert_macros.svh
// Assertion macros shared by the spline sampler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CCBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CCBS_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: hdl/ccbs_pkg.sv
// Shared constants, types and the basis weight table of the spline sampler.
package ccbs_pkg;

   // Samples per segment and the derived fixed-point geometry
   localparam int SAMPLES   = 16;
   localparam int SEG_D     = SAMPLES - 1;
   localparam int D3        = SEG_D * SEG_D * SEG_D;
   localparam int DEN       = 6 * D3;
   localparam int D2        = 2 * DEN;
   localparam int WGT_W     = $clog2(4 * D3 + 1);
   localparam int PROD_W    = 16 + WGT_W + 1;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int NB_W      = 17 + $clog2(DEN + 1);
   localparam int EXT_W     = NB_W + 4;
   localparam int RECIP_W   = NB_W - $clog2(D2) + 2;
   localparam int Q_W       = 17;
   localparam int D2_W      = $clog2(D2 + 1);
   localparam int QD_W      = Q_W + D2_W;
   localparam int RW_W      = ((QD_W > NB_W) ? QD_W : NB_W) + 1;
   localparam int J_W       = (SAMPLES > 2) ? $clog2(SAMPLES) : 1;

   // Rounding bias shifts the numerator positive; reciprocal replaces the divide
   localparam longint BIAS  = longint'(DEN) + 64'sd32768 * longint'(D2);
   localparam longint RECIP = (64'sd1 <<< NB_W) / longint'(D2);

   localparam logic [J_W-1:0]     J_LAST  = J_W'(SAMPLES - 1);
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
   localparam logic [D2_W-1:0]    D2_V    = D2_W'(D2);
   localparam logic [15:0]        COORD_MAX = 16'h7fff;

   // Segment index of the final wrap segment of a close
   localparam logic [1:0] SEG_LAST_CLOSE = 2'd2;
   localparam logic [1:0] SEG_LAST_POINT = 2'd0;
   localparam logic [1:0] SEEN_FULL      = 2'd3;

   // Command queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      KIND_POINT = 1'b0,
      KIND_CLOSE = 1'b1
   } kind_type;

   typedef struct packed {
      logic signed [15:0] y;
      logic signed [15:0] x;
   } point_type;

   // One queued job: a six-point window, one segment or three wrap segments
   typedef struct packed {
      logic                close;
      point_type [5:0]     pts;
   } seg_cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef logic signed [EXT_W-1:0]  ext_type;
   typedef logic [NB_W-1:0]          nb_type;
   typedef logic [NB_W+RECIP_W-1:0]  rp_type;
   typedef logic [Q_W-1:0]           q_type;
   typedef logic [Q_W:0]             qx_type;
   typedef logic [QD_W-1:0]          qd_type;
   typedef logic [RW_W-1:0]          rw_type;

   typedef logic [SAMPLES-1:0][3:0][WGT_W-1:0] wgt_table_type;

   // Basis weights scaled by 6*d^3, one row per sample position
   function automatic wgt_table_type make_wgt_table();
      wgt_table_type t;
      int w0, w1, w2, w3;
      for (int j = 0; j < SAMPLES; j++) begin
         w0 = (SEG_D - j) * (SEG_D - j) * (SEG_D - j);
         w1 = 3 * j * j * j - 6 * j * j * SEG_D + 4 * D3;
         w2 = -3 * j * j * j + 3 * j * j * SEG_D + 3 * j * SEG_D * SEG_D + D3;
         w3 = j * j * j;
         t[j][0] = WGT_W'(w0);
         t[j][1] = WGT_W'(w1);
         t[j][2] = WGT_W'(w2);
         t[j][3] = WGT_W'(w3);
      end
      return t;
   endfunction

   localparam wgt_table_type WGT_TABLE = make_wgt_table();

endpackage

// File: hdl/ccbs_front.sv
// Front end: takes input transactions, tracks control points, queues segment jobs.
`include "assert_macros.svh"

module ccbs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,   // point_x [15:0], point_y [31:16]
   input  logic                      req_tuser,   // kind [0]
   input  ccbs_pkg::q_status_type    q_status,
   output logic                      q_push,
   output ccbs_pkg::seg_cmd_type     q_push_data
);
   import ccbs_pkg::*;

   point_type        first_ff [3];
   point_type        recent_ff [3];
   logic [1:0]       seen_ff, seen_in;
   logic             accept;
   kind_type         kind;
   point_type        pt;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign pt         = point_type'(req_tdata);

   // Build the job window and decide whether it is queued
   always_comb begin
      q_push_data.close  = (kind == KIND_CLOSE);
      q_push_data.pts[0] = recent_ff[0];
      q_push_data.pts[1] = recent_ff[1];
      q_push_data.pts[2] = recent_ff[2];
      q_push_data.pts[3] = (kind == KIND_CLOSE) ? first_ff[0] : pt;
      q_push_data.pts[4] = first_ff[1];
      q_push_data.pts[5] = first_ff[2];
      q_push = accept && (seen_ff == SEEN_FULL);
   end

   // Count points, saturate at three, clear on close
   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         unique case (kind)
            KIND_POINT: if (seen_ff != SEEN_FULL) seen_in = seen_ff + 2'd1;
            KIND_CLOSE: seen_in = '0;
            default:    seen_in = seen_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // Capture the first points and slide the recent window
   always_ff @(posedge clock) begin
      if (accept && kind == KIND_POINT) begin
         if (seen_ff != SEEN_FULL) begin
            first_ff[seen_ff] <= pt;
         end
         recent_ff[0] <= recent_ff[1];
         recent_ff[1] <= recent_ff[2];
         recent_ff[2] <= pt;
      end
   end

   `CCBS_ASSERT(a_push_needs_three, q_push |-> seen_ff == SEEN_FULL && !q_status.full,
                "segment job queued without three stored points")

endmodule

// File: hdl/ccbs_queue.sv
// Short job queue between the front end and the sampler.
`include "assert_macros.svh"

module ccbs_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ccbs_pkg::seg_cmd_type     push_data,
   input  logic                      pop,
   output ccbs_pkg::seg_cmd_type     pop_data,
   output ccbs_pkg::q_status_type    status
);
   import ccbs_pkg::*;

   seg_cmd_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CCBS_NEVER(a_no_underflow, pop && !status.valid, "job queue popped while empty")
   `CCBS_ASSERT(a_count_track, (push && !pop && !status.full) |=> count_ff == $past(count_ff) + 1'b1,
                "job queue occupancy lost a push")

endmodule

// File: hdl/ccbs_sampler.sv
// Back end: steps through segment samples and evaluates the blended points.
`include "assert_macros.svh"

module ccbs_sampler (
   input  logic                      clock,
   input  logic                      reset,
   input  ccbs_pkg::q_status_type    q_status,
   input  ccbs_pkg::seg_cmd_type     q_data,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,   // curve_x [15:0], curve_y [31:16]
   output logic                      rsp_tlast    // run_last
);
   import ccbs_pkg::*;

   // Sequencer state
   logic             busy_ff, busy_in;
   seg_cmd_type      cmd_ff, cmd_in;
   logic [1:0]       seg_ff, seg_in;
   logic [J_W-1:0]   j_ff, j_in;
   logic [1:0]       seg_last;
   logic             adv, issue, final_sample;

   // Pipeline registers
   logic             s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic             s6_valid_ff, out_valid_ff;
   logic             s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff, s5_last_ff, s6_last_ff;
   logic             out_last_ff;
   point_type [3:0]  s1_pts_ff, s1_pts_in;
   logic [J_W-1:0]   s1_j_ff;
   prod_type         s2_prod_ff [2][4];
   prod_type         s2_prod_in [2][4];
   pair_type         s3_sum_ff [2][2];
   pair_type         s3_sum_in [2][2];
   ext_type          s4_ext [2];
   ext_type          s4_num [2];
   nb_type           s4_n_ff [2];
   nb_type           s4_n_in [2];
   rp_type           s5_rp [2];
   q_type            s5_q_ff [2];
   q_type            s5_q_in [2];
   nb_type           s5_n_ff [2];
   qd_type           s6_qd_ff [2];
   qd_type           s6_qd_in [2];
   q_type            s6_q_ff [2];
   nb_type           s6_n_ff [2];
   rw_type           rem [2];
   qx_type           q_fix [2];
   logic [15:0]      coord_in [2];
   point_type        out_pt_ff;

   assign adv          = !out_valid_ff || rsp_tready;
   assign seg_last     = cmd_ff.close ? SEG_LAST_CLOSE : SEG_LAST_POINT;
   assign final_sample = busy_ff && (j_ff == J_LAST) && (seg_ff == seg_last);
   assign issue        = busy_ff && adv;
   assign q_pop        = adv && q_status.valid && (!busy_ff || final_sample);

   // Step sample index and segment, load the next job on the last sample or when idle
   always_comb begin
      busy_in = busy_ff;
      cmd_in  = cmd_ff;
      seg_in  = seg_ff;
      j_in    = j_ff;
      if (issue) begin
         if (j_ff == J_LAST) begin
            j_in = '0;
            if (seg_ff == seg_last) begin
               busy_in = 1'b0;
            end else begin
               seg_in = seg_ff + 2'd1;
            end
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
      if (q_pop) begin
         cmd_in  = q_data;
         busy_in = 1'b1;
         seg_in  = '0;
         j_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      seg_ff <= seg_in;
      j_ff   <= j_in;
   end

   // Pick the four control points of the current segment
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s1_pts_in[k] = cmd_ff.pts[{1'b0, seg_ff} + 3'(k)];
      end
   end

   // Weight each control point
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s2_prod_in[0][k] = prod_type'(s1_pts_ff[k].x)
                          * prod_type'($signed({1'b0, WGT_TABLE[s1_j_ff][k]}));
         s2_prod_in[1][k] = prod_type'(s1_pts_ff[k].y)
                          * prod_type'($signed({1'b0, WGT_TABLE[s1_j_ff][k]}));
      end
   end

   // Sum, bias for rounding, reciprocal multiply, remainder product
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         s3_sum_in[c][0] = pair_type'(s2_prod_ff[c][0]) + pair_type'(s2_prod_ff[c][1]);
         s3_sum_in[c][1] = pair_type'(s2_prod_ff[c][2]) + pair_type'(s2_prod_ff[c][3]);
         s4_ext[c]  = ext_type'(s3_sum_ff[c][0]) + ext_type'(s3_sum_ff[c][1]);
         s4_num[c]  = (s4_ext[c] <<< 1) + ext_type'(BIAS);
         s4_n_in[c] = s4_num[c][NB_W-1:0];
         s5_rp[c]   = rp_type'(s4_n_ff[c]) * rp_type'(RECIP_V);
         s5_q_in[c] = s5_rp[c][NB_W +: Q_W];
         s6_qd_in[c] = qd_type'(s5_q_ff[c]) * qd_type'(D2_V);
      end
   end

   // Correct the quotient estimate, remove the offset, saturate
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         rem[c]   = rw_type'(s6_n_ff[c]) - rw_type'(s6_qd_ff[c]);
         q_fix[c] = (rem[c] >= rw_type'(D2_V)) ? qx_type'(s6_q_ff[c]) + 1'b1
                                                 : qx_type'(s6_q_ff[c]);
         if (|q_fix[c][Q_W:16]) begin
            coord_in[c] = COORD_MAX;
         end else begin
            coord_in[c] = {~q_fix[c][15], q_fix[c][14:0]};
         end
      end
   end

   // Valid chain, held while the output stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= busy_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         out_valid_ff <= s6_valid_ff;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pts_ff   <= s1_pts_in;
         s1_j_ff     <= j_ff;
         s1_last_ff  <= final_sample;
         s2_prod_ff  <= s2_prod_in;
         s2_last_ff  <= s1_last_ff;
         s3_sum_ff   <= s3_sum_in;
         s3_last_ff  <= s2_last_ff;
         s4_n_ff     <= s4_n_in;
         s4_last_ff  <= s3_last_ff;
         s5_q_ff     <= s5_q_in;
         s5_n_ff     <= s4_n_ff;
         s5_last_ff  <= s4_last_ff;
         s6_qd_ff    <= s6_qd_in;
         s6_q_ff     <= s5_q_ff;
         s6_n_ff     <= s5_n_ff;
         s6_last_ff  <= s5_last_ff;
         out_pt_ff.x <= coord_in[0];
         out_pt_ff.y <= coord_in[1];
         out_last_ff <= s6_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pt_ff;
   assign rsp_tlast  = out_last_ff;

   `CCBS_ASSERT(a_point_job_one_segment, (busy_ff && !cmd_ff.close) |-> seg_ff == SEG_LAST_POINT,
                "point job stepped past its single segment")
   `CCBS_ASSERT(a_pop_on_boundary, q_pop |-> (!busy_ff || final_sample),
                "job loaded while a segment was still running")

endmodule

// File: hdl/closed_cubic_bspline_sampler_top.sv
// Top level of the closed uniform cubic B-spline sampler.
// Control points and close requests arrive on the req_ stream; req_tuser = 0 is a point,
// 1 closes the curve. From the fourth point on, each point yields SAMPLES = 16 curve
// points of one segment; a close with at least three stored points yields the three
// wrap segments (48 points) and then starts a new curve, a close with fewer yields
// nothing. Results leave on the rsp_ stream at one per clock while rsp_tready stays high,
// with rsp_tlast on the final point caused by an input transaction. The sampler evaluates
// one sample per clock unless the output stalls. A four-entry job queue lets the input
// side run ahead, and inputs that yield no output only need a free queue slot.
module closed_cubic_bspline_sampler_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // point_x [15:0], point_y [31:16]
   input  logic         req_tuser,   // kind [0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // curve_x [15:0], curve_y [31:16]
   output logic         rsp_tlast    // run_last
);
   import ccbs_pkg::*;

   q_status_type  q_status;
   seg_cmd_type   q_push_data;
   seg_cmd_type   q_pop_data;
   logic          q_push;
   logic          q_pop;

   ccbs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   ccbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   ccbs_sampler u_sampler (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: sim/closed_cubic_bspline_sampler_top_tb.sv
// Self-checking testbench for the closed cubic B-spline sampler.
`timescale 1ns / 100ps

module closed_cubic_bspline_sampler_top_tb;
   import ccbs_pkg::*;

   localparam int RESET_CYCLES   = 12;
   localparam int IDLE_PCT       = 23;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 30;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 82;

   // Predicts the curve samples of each transaction and checks them in order
   class spline_scoreboard;
      typedef struct {
         logic signed [15:0] x;
         logic signed [15:0] y;
         logic               last;
      } curve_sample_type;

      point_type        first_pts [3];
      point_type        recent_pts [3];
      logic [1:0]       pts_taken;
      curve_sample_type expected_q [$];
      int               errors;

      function new();
         errors = 0;
         clear_curve();
      endfunction

      function void clear_curve();
         for (int i = 0; i < 3; i++) begin
            first_pts[i]  = '0;
            recent_pts[i] = '0;
         end
         pts_taken = '0;
      endfunction

      // Exact weighted sum over 6*d^3, rounded half up and clamped to 16 bits
      function logic signed [15:0] blend_coord(longint c0, longint c1, longint c2,
                                               longint c3, longint j);
         longint d, d3, w0, w1, w2, w3, num2, den2, q;
         d    = SAMPLES - 1;
         d3   = d * d * d;
         w0   = (d - j) * (d - j) * (d - j);
         w1   = 3 * j * j * j - 6 * j * j * d + 4 * d3;
         w2   = -3 * j * j * j + 3 * j * j * d + 3 * j * d * d + d3;
         w3   = j * j * j;
         num2 = 2 * (w0 * c0 + w1 * c1 + w2 * c2 + w3 * c3) + 6 * d3;
         den2 = 12 * d3;
         q    = num2 / den2;
         if ((num2 % den2) != 0 && num2 < 0)
            q = q - 1;
         if (q > 32767)
            q = 32767;
         if (q < -32768)
            q = -32768;
         return q[15:0];
      endfunction

      function void emit_segment(point_type a, point_type b, point_type c, point_type e);
         curve_sample_type s;
         for (int j = 0; j < SAMPLES; j++) begin
            s.x    = blend_coord(a.x, b.x, c.x, e.x, j);
            s.y    = blend_coord(a.y, b.y, c.y, e.y, j);
            s.last = 1'b0;
            expected_q.insert(expected_q.size(), s);
         end
      endfunction

      // Note one accepted input transaction and queue the samples it yields
      function void note_request(kind_type kind, point_type pt);
         int               old_size;
         curve_sample_type tail;
         old_size = expected_q.size();
         if (kind == KIND_POINT) begin
            if (pts_taken == SEEN_FULL) begin
               emit_segment(recent_pts[0], recent_pts[1], recent_pts[2], pt);
            end else begin
               first_pts[pts_taken] = pt;
               pts_taken = pts_taken + 2'd1;
            end
            recent_pts[0] = recent_pts[1];
            recent_pts[1] = recent_pts[2];
            recent_pts[2] = pt;
         end else begin
            if (pts_taken == SEEN_FULL) begin
               emit_segment(recent_pts[0], recent_pts[1], recent_pts[2], first_pts[0]);
               emit_segment(recent_pts[1], recent_pts[2], first_pts[0], first_pts[1]);
               emit_segment(recent_pts[2], first_pts[0], first_pts[1], first_pts[2]);
            end
            clear_curve();
         end
         // Flag the final sample of this transaction
         if (expected_q.size() > old_size) begin
            tail = expected_q[expected_q.size() - 1];
            tail.last = 1'b1;
            expected_q[expected_q.size() - 1] = tail;
         end
      endfunction

      // Compare one accepted result transaction with the oldest expected sample
      function void check_response(logic [31:0] data, logic last);
         curve_sample_type s;
         if (expected_q.size() == 0) begin
            $error("unexpected result: curve_x %0d curve_y %0d run_last %0b",
                   $signed(data[15:0]), $signed(data[31:16]), last);
            errors++;
            return;
         end
         s = expected_q.pop_front();
         if (data[15:0] !== s.x) begin
            $error("curve_x mismatch: expected %0d, actual %0d", s.x, $signed(data[15:0]));
            errors++;
         end
         if (data[31:16] !== s.y) begin
            $error("curve_y mismatch: expected %0d, actual %0d", s.y, $signed(data[31:16]));
            errors++;
         end
         if (last !== s.last) begin
            $error("run_last mismatch: expected %0b, actual %0b", s.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   logic        hold_req   = 1'b0;
   logic        rsp_calm   = 1'b0;
   logic        tx_calm    = 1'b0;
   int          hold_left  = 0;
   logic        hold_done  = 1'b0;
   int          quiet_cycles = 0;

   spline_scoreboard sb = new();

   closed_cubic_bspline_sampler_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: one long hold-off on request, calm stretches, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Check every accepted result transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tlast);
   end

   // Abort when nothing moves on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(0, 7))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic point_type rand_point();
      point_type pt;
      pt.x = rand_coord();
      pt.y = rand_coord();
      return pt;
   endfunction

   // Offer one transaction, with random gaps unless the sender is in a calm stretch
   task automatic send_item(kind_type kind, point_type pt);
      while (!tx_calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pt;
      req_tuser  <= kind;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_request(kind, pt);
   endtask

   // Send a curve of random points followed by a close
   task automatic send_curve(int n_points);
      for (int i = 0; i < n_points; i++)
         send_item(KIND_POINT, rand_point());
      send_item(KIND_CLOSE, rand_point());
   endtask

   function automatic point_type mk_point(logic signed [15:0] x, logic signed [15:0] y);
      point_type pt;
      pt.x = x;
      pt.y = y;
      return pt;
   endfunction

   initial begin
      int sent;
      int n_points;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Close on an empty curve, then with one and two points: no samples
      send_curve(0);
      send_item(KIND_POINT, mk_point(16'sh7fff, 16'sh8000));
      send_item(KIND_CLOSE, mk_point(16'sh7fff, 16'sh7fff));
      send_item(KIND_POINT, mk_point(16'sh8000, 16'sh7fff));
      send_item(KIND_POINT, mk_point(16'sh0000, 16'shffff));
      send_item(KIND_CLOSE, mk_point(16'sh0000, 16'sh0000));

      // Close with exactly three points: wrap segments from the first points only
      send_item(KIND_POINT, mk_point(16'sh8000, 16'sh7fff));
      send_item(KIND_POINT, mk_point(16'sh7fff, 16'sh7fff));
      send_item(KIND_POINT, mk_point(16'sh0000, 16'sh0000));
      send_item(KIND_CLOSE, mk_point(16'sh8000, 16'sh8000));

      // Full-scale corners, window sliding past saturation, then close
      send_item(KIND_POINT, mk_point(16'sh7fff, 16'sh7fff));
      send_item(KIND_POINT, mk_point(16'sh7fff, 16'sh7fff));
      send_item(KIND_POINT, mk_point(16'sh7fff, 16'sh7fff));
      send_item(KIND_POINT, mk_point(16'sh7fff, 16'sh7fff));
      send_item(KIND_POINT, mk_point(16'sh8000, 16'sh8000));
      send_item(KIND_POINT, mk_point(16'sh8000, 16'sh7fff));
      send_item(KIND_POINT, mk_point(16'sh5555, 16'shaaaa));
      send_item(KIND_CLOSE, mk_point(16'shffff, 16'sh0001));

      // Random curves; the receiver holds off at the start while the sender keeps pushing
      sent = 0;
      hold_req <= 1'b1;
      while (sent < RANDOM_ITEMS) begin
         tx_calm  <= (sent < 12) || (sent >= 40 && sent < 70);
         rsp_calm <= (sent >= 40 && sent < 70);
         case ($urandom_range(0, 9))
            0:       n_points = $urandom_range(0, 2);
            1:       n_points = 3;
            default: n_points = $urandom_range(4, 8);
         endcase
         send_curve(n_points);
         sent = sent + n_points + 1;
      end
      req_tvalid <= 1'b0;
      tx_calm    <= 1'b0;
      rsp_calm   <= 1'b0;

      // Drain the remaining samples, then keep watching for strays over the drain period
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
